@@ hw/rtl/dmx_pkg.sv @@
package dmx_pkg;

    // fixed field widths of the ports
    localparam int KIND_W  = 2;
    localparam int SITE_W  = 3;
    localparam int STAMP_W = 16;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_LOCAL_REQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOTE_REQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOTE_REPLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE      = 2'd3;

    // result message kinds
    localparam logic [KIND_W-1:0] MSG_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] MSG_REPLY   = 2'd1;
    localparam logic [KIND_W-1:0] MSG_GRANT   = 2'd2;

    // node modes
    localparam logic [1:0] MODE_IDLE       = 2'd0;
    localparam logic [1:0] MODE_REQUESTING = 2'd1;
    localparam logic [1:0] MODE_CRITICAL   = 2'd2;

    typedef struct packed {
        logic update;
        logic emit;
    } dmx_cmd_t;

    typedef struct packed {
        logic pending_any;
        logic pending_last;
        logic out_free;
    } dmx_status_t;

endpackage

@@ hw/rtl/distributed_mutex_node.sv @@
// One node of Ricart-Agrawala mutual exclusion driven by a Lamport clock.
// Input beats are local requests, remote requests, remote replies and local
// releases; output beats are request, reply and grant messages, each with its
// destination site and the node clock, and last marks the final message that
// one input beat causes. An input beat is evaluated when it is accepted and
// then sends its messages, if any: a local request that is acted on sends a
// request to every other site, a release a reply to each deferred site.
// Output stalls hold the sending once the output register is full. The
// output register takes one destination a cycle, while it is free, from the
// mask of sites still owed a message; in_ready is low until the mask is
// drained, while the last message may still wait in the output register.
// The clock saturates at its top value and incoming stamps beyond it are
// clipped. The user must write own_site through the cfg channel only while
// the node is idle; the block itself does not enforce it. Values not below
// SITE_COUNT act as the highest site. There is no clearing pass after reset.
module distributed_mutex_node #(
    parameter int SITE_COUNT = 6,
    parameter int CLOCK_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dmx_pkg::SITE_W-1:0]  cfg_data,
    // input beats
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dmx_pkg::KIND_W-1:0]  kind,
    input  logic [dmx_pkg::SITE_W-1:0]  source_site,
    input  logic [dmx_pkg::STAMP_W-1:0] stamp,
    // output beats
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dmx_pkg::KIND_W-1:0]  message_kind,
    output logic [dmx_pkg::SITE_W-1:0]  dest_site,
    output logic [dmx_pkg::STAMP_W-1:0] out_stamp,
    output logic                        last
);

    dmx_pkg::dmx_cmd_t    cmd;
    dmx_pkg::dmx_status_t status;

    // the register is always writable; the user must write it only between items, the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencing: evaluate on accept, then drain destinations
    dmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // clock, mode, deferral mask and message output register
    dmx_datapath #(
        .SITE_COUNT (SITE_COUNT),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .source_site  (source_site),
        .stamp        (stamp),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .message_kind (message_kind),
        .dest_site    (dest_site),
        .out_stamp    (out_stamp),
        .last         (last)
    );

endmodule

@@ hw/rtl/dmx_ctrl.sv @@
module dmx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output dmx_pkg::dmx_cmd_t    cmd,
    input  dmx_pkg::dmx_status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.update = in_valid && (state_reg == ST_IDLE);
    assign cmd.emit   = (state_reg == ST_EMIT) && status.pending_any && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // leave once no destination is pending or the final one goes to the output register
                if (!status.pending_any)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free && status.pending_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/dmx_datapath.sv @@
module dmx_datapath #(
    parameter int SITE_COUNT = 6,
    parameter int CLOCK_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dmx_pkg::SITE_W-1:0]  cfg_data,
    input  logic [dmx_pkg::KIND_W-1:0]  kind,
    input  logic [dmx_pkg::SITE_W-1:0]  source_site,
    input  logic [dmx_pkg::STAMP_W-1:0] stamp,
    input  dmx_pkg::dmx_cmd_t           cmd,
    output dmx_pkg::dmx_status_t        status,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [dmx_pkg::KIND_W-1:0]  message_kind,
    output logic [dmx_pkg::SITE_W-1:0]  dest_site,
    output logic [dmx_pkg::STAMP_W-1:0] out_stamp,
    output logic                        last
);

    localparam int IDX_W  = ($clog2(SITE_COUNT) > dmx_pkg::SITE_W) ?
                            $clog2(SITE_COUNT) : dmx_pkg::SITE_W;
    localparam int CNT_W  = $clog2(SITE_COUNT);
    localparam int WIDE_W = (CLOCK_BITS > dmx_pkg::STAMP_W) ? CLOCK_BITS : dmx_pkg::STAMP_W;
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX  = '1;
    localparam logic [31:0]           SITE_LIMIT = 32'(SITE_COUNT);
    localparam logic [CNT_W-1:0]      GRANT_AT   = CNT_W'(SITE_COUNT - 2);

    // protocol state
    logic [dmx_pkg::SITE_W-1:0] own_site_reg;
    logic [CLOCK_BITS-1:0]      clock_reg;
    logic [CLOCK_BITS-1:0]      clock_next;
    logic [CLOCK_BITS-1:0]      req_stamp_reg;
    logic [CLOCK_BITS-1:0]      req_stamp_next;
    logic [1:0]                 mode_reg;
    logic [1:0]                 mode_next;
    logic [CNT_W-1:0]           replies_reg;
    logic [CNT_W-1:0]           replies_next;
    logic [SITE_COUNT-1:0]      deferred_reg;
    logic [SITE_COUNT-1:0]      deferred_next;

    // destinations still to send for the current item
    logic [SITE_COUNT-1:0]      pending_reg;
    logic [SITE_COUNT-1:0]      pending_next;
    logic [dmx_pkg::KIND_W-1:0] msg_kind_reg;
    logic [dmx_pkg::KIND_W-1:0] msg_kind_next;

    // output register
    logic                        out_valid_reg;
    logic [dmx_pkg::KIND_W-1:0]  out_kind_reg;
    logic [dmx_pkg::SITE_W-1:0]  out_dest_reg;
    logic [dmx_pkg::STAMP_W-1:0] out_stamp_reg;
    logic                        out_last_reg;

    logic [IDX_W-1:0]      me;
    logic [IDX_W-1:0]      src;
    logic                  src_ok;
    logic [WIDE_W-1:0]     stamp_wide;
    logic [CLOCK_BITS-1:0] stamp_sat;
    logic [CLOCK_BITS-1:0] clock_max;
    logic [CLOCK_BITS-1:0] clock_inc;
    logic [CLOCK_BITS-1:0] remote_inc;
    logic                  wins;
    logic [SITE_COUNT-1:0] me_oh;
    logic [SITE_COUNT-1:0] src_oh;
    logic [SITE_COUNT-1:0] low_oh;
    logic [SITE_COUNT-1:0] rest;
    logic [IDX_W-1:0]      low_idx;

    always_comb
    begin
        me = ({29'd0, own_site_reg} >= SITE_LIMIT) ? IDX_W'(SITE_COUNT - 1)
                                                   : IDX_W'(own_site_reg);
        src    = IDX_W'(source_site);
        src_ok = ({29'd0, source_site} < SITE_LIMIT) && (src != me);

        // stamps beyond the clock range clip to its top
        stamp_wide = WIDE_W'(stamp);
        stamp_sat  = (stamp_wide > WIDE_W'(CLOCK_MAX)) ? CLOCK_MAX : CLOCK_BITS'(stamp_wide);
        clock_max  = (stamp_sat > clock_reg) ? stamp_sat : clock_reg;
        clock_inc  = (clock_reg == CLOCK_MAX) ? clock_reg : clock_reg + 1'b1;
        remote_inc = (clock_max == CLOCK_MAX) ? clock_max : clock_max + 1'b1;
        wins = (stamp_sat < req_stamp_reg) || ((stamp_sat == req_stamp_reg) && (src < me));

        for (int i = 0; i < SITE_COUNT; i++)
        begin
            me_oh[i]  = (IDX_W'(i) == me);
            src_oh[i] = (IDX_W'(i) == src);
        end

        // lowest pending destination goes out first
        low_oh  = pending_reg & (~pending_reg + 1'b1);
        rest    = pending_reg & ~low_oh;
        low_idx = '0;
        for (int i = 0; i < SITE_COUNT; i++)
        begin
            if (low_oh[i])
            begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        clock_next     = clock_reg;
        req_stamp_next = req_stamp_reg;
        mode_next      = mode_reg;
        replies_next   = replies_reg;
        deferred_next  = deferred_reg;
        pending_next   = pending_reg;
        msg_kind_next  = msg_kind_reg;
        if (cmd.update)
        begin
            case (kind)
                dmx_pkg::KIND_LOCAL_REQ:
                begin
                    if (mode_reg == dmx_pkg::MODE_IDLE)
                    begin
                        clock_next     = clock_inc;
                        req_stamp_next = clock_inc;
                        mode_next      = dmx_pkg::MODE_REQUESTING;
                        replies_next   = '0;
                        pending_next   = ~me_oh;
                        msg_kind_next  = dmx_pkg::MSG_REQUEST;
                    end
                end
                dmx_pkg::KIND_REMOTE_REQ:
                begin
                    if (src_ok)
                    begin
                        clock_next = remote_inc;
                        if ((mode_reg == dmx_pkg::MODE_IDLE) ||
                            ((mode_reg == dmx_pkg::MODE_REQUESTING) && wins))
                        begin
                            pending_next  = src_oh;
                            msg_kind_next = dmx_pkg::MSG_REPLY;
                        end
                        else
                        begin
                            deferred_next = deferred_reg | src_oh;
                        end
                    end
                end
                dmx_pkg::KIND_REMOTE_REPLY:
                begin
                    if (src_ok && (mode_reg == dmx_pkg::MODE_REQUESTING))
                    begin
                        replies_next = replies_reg + 1'b1;
                        if (replies_reg == GRANT_AT)
                        begin
                            mode_next     = dmx_pkg::MODE_CRITICAL;
                            pending_next  = me_oh;
                            msg_kind_next = dmx_pkg::MSG_GRANT;
                        end
                    end
                end
                dmx_pkg::KIND_RELEASE:
                begin
                    if (mode_reg == dmx_pkg::MODE_CRITICAL)
                    begin
                        clock_next    = clock_inc;
                        mode_next     = dmx_pkg::MODE_IDLE;
                        pending_next  = deferred_reg;
                        deferred_next = '0;
                        msg_kind_next = dmx_pkg::MSG_REPLY;
                    end
                end
                default:
                begin
                    clock_next = clock_reg;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            pending_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_site_reg  <= '0;
            clock_reg     <= '0;
            req_stamp_reg <= '0;
            mode_reg      <= dmx_pkg::MODE_IDLE;
            replies_reg   <= '0;
            deferred_reg  <= '0;
            pending_reg   <= '0;
            msg_kind_reg  <= dmx_pkg::MSG_REQUEST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_site_reg <= cfg_data;
            end
            clock_reg     <= clock_next;
            req_stamp_reg <= req_stamp_next;
            mode_reg      <= mode_next;
            replies_reg   <= replies_next;
            deferred_reg  <= deferred_next;
            pending_reg   <= pending_next;
            msg_kind_reg  <= msg_kind_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // message payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= msg_kind_reg;
            out_dest_reg  <= dmx_pkg::SITE_W'(low_idx);
            out_stamp_reg <= dmx_pkg::STAMP_W'(clock_reg);
            out_last_reg  <= (rest == '0);
        end
    end

    assign status.pending_any  = |pending_reg;
    assign status.pending_last = (rest == '0);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign message_kind = out_kind_reg;
    assign dest_site    = out_dest_reg;
    assign out_stamp    = out_stamp_reg;
    assign last         = out_last_reg;

endmodule

@@ hw/rtl/dmx_checker.sv @@
module dmx_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dmx_pkg::KIND_W-1:0]  message_kind,
    input logic [dmx_pkg::SITE_W-1:0]  dest_site,
    input logic [dmx_pkg::STAMP_W-1:0] out_stamp,
    input logic                        last
);

    // a stalled message holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(message_kind) &&
            $stable(dest_site) && $stable(out_stamp) && $stable(last))
        else $error("stalled output beat changed");

    // after accepting a beat the node is busy evaluating it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    // a grant is always the only message of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (message_kind == dmx_pkg::MSG_GRANT) |-> last)
        else $error("grant without last");

    // never a kind outside request, reply and grant
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (message_kind == dmx_pkg::MSG_REQUEST) ||
            (message_kind == dmx_pkg::MSG_REPLY) || (message_kind == dmx_pkg::MSG_GRANT))
        else $error("bad message kind");

endmodule

bind distributed_mutex_node dmx_checker u_dmx_checker (.*);
